// ===== hdl/urfp_pkg.sv =====
`default_nettype none
package urfp_pkg;

  // Ring of stored readings
  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // Millimetre values and the running sum over the ring
  localparam int MM_W   = 15;
  localparam int SUM_W  = MM_W + CNT_W;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  // 254*in + 5 for in up to 999 fits in 18 bits
  localparam int X_W = 18;

  // x/10 == (x * ceil(2^24/10)) >> 24, exact for x below 2^22
  localparam int            RECIP_W  = 21;
  localparam logic [20:0]   MM_RECIP = 21'd1677722;
  localparam int            MM_SHIFT = 24;
  localparam logic [MM_W-1:0] MM_MAX = 15'd25375;

  localparam logic [7:0] BYTE_START = 8'h52;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  localparam int         AVG_W           = 5;
  localparam logic [4:0] AVG_COUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_CONV,
    ST_SETUP,
    ST_WALK,
    ST_DIV,
    ST_PUB
  } urfp_state_t;

  typedef struct packed {
    logic load;
    logic parse;
    logic conv;
    logic setup;
    logic walk;
    logic div_load;
    logic div_step;
    logic publish;
  } urfp_cmd_t;

  typedef struct packed {
    logic complete;
    logic walk_done;
    logic div_last;
  } urfp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/urfp_ram.sv =====
`default_nettype none
module urfp_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output      logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/urfp_ctrl.sv =====
`default_nettype none
module urfp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      urfp_pkg::urfp_cmd_t cmd,
  input  wire urfp_pkg::urfp_stat_t stat
);
  import urfp_pkg::*;

  urfp_state_t state;
  urfp_state_t state_next;
  logic        slot_free;

  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_PARSE;
      end
      ST_PARSE: begin
        state_next = stat.complete ? ST_CONV : ST_SETUP;
      end
      ST_CONV:  state_next = ST_SETUP;
      ST_SETUP: state_next = ST_WALK;
      ST_WALK: begin
        if (stat.walk_done) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_last) state_next = ST_PUB;
      end
      ST_PUB: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_PARSE: cmd.parse = 1'b1;
      ST_CONV:  cmd.conv  = 1'b1;
      ST_SETUP: cmd.setup = 1'b1;
      ST_WALK: begin
        cmd.walk     = 1'b1;
        cmd.div_load = stat.walk_done;
      end
      ST_DIV:   cmd.div_step = 1'b1;
      ST_PUB:   cmd.publish  = slot_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/urfp_dp.sv =====
`default_nettype none
module urfp_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire urfp_pkg::urfp_cmd_t      cmd,
  output      urfp_pkg::urfp_stat_t     stat,
  input  wire logic                     cfg_we,
  input  wire logic [urfp_pkg::AVG_W-1:0] cfg_data,
  input  wire logic [7:0]               rx_byte,
  output      logic                     frame_done,
  output      logic [urfp_pkg::MM_W-1:0] distance_mm,
  output      logic [urfp_pkg::MM_W-1:0] average_mm
);
  import urfp_pkg::*;

  localparam int PROD_W = X_W + RECIP_W;

  // config
  logic [AVG_W-1:0] avg_count;
  logic [CNT_W-1:0] n_sat;

  // frame parser
  logic [7:0]       byte_q;
  logic             frame_open;
  logic [1:0]       digit_count;
  logic [3:0]       digit_store [3];
  logic             is_digit;
  logic [X_W-1:0]   x_next;
  logic [X_W-1:0]   x_reg;

  // conversion and ring
  logic [PROD_W-1:0] prod;
  logic [MM_W-1:0]   mm;
  logic [SLOT_W-1:0] write_slot;
  logic [RING_DEPTH-1:0] vld;
  logic              done_flag;
  logic [MM_W-1:0]   last_distance;
  logic [MM_W-1:0]   last_average;

  // averaging walk
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_dec;
  logic [CNT_W-1:0]  remain;
  logic              pend;
  logic              pend_ok;
  logic [MM_W-1:0]   ram_q;
  logic [MM_W-1:0]   entry;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  good;

  // restoring divider
  logic [SUM_W-1:0]  quo;
  logic [SUM_W-1:0]  quo_next;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    shifted;
  logic              ge;
  logic [DCNT_W-1:0] dcnt;

  assign n_sat = (32'(avg_count) > 32'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) : CNT_W'(avg_count);

  assign is_digit = (byte_q >= BYTE_ZERO) && (byte_q <= BYTE_NINE);

  assign stat.complete = (byte_q != BYTE_START) && frame_open &&
                         (digit_count == 2'd3) && (byte_q == BYTE_CR);

  assign x_next = X_W'(digit_store[0]) * X_W'(25400) +
                  X_W'(digit_store[1]) * X_W'(2540) +
                  X_W'(digit_store[2]) * X_W'(254) + X_W'(5);

  assign prod = PROD_W'(x_reg) * PROD_W'(MM_RECIP);
  assign mm   = prod[MM_SHIFT +: MM_W];

  assign slot_dec = (slot == '0) ? SLOT_W'(RING_DEPTH - 1) : slot - SLOT_W'(1);
  assign entry    = pend_ok ? ram_q : '0;

  assign stat.walk_done = (remain == '0) && !pend;

  assign shifted  = {rem, quo[SUM_W-1]};
  assign ge       = shifted >= {1'b0, good};
  assign quo_next = {quo[SUM_W-2:0], ge};
  assign stat.div_last = (dcnt == DCNT_W'(1));

  urfp_ram #(
    .WIDTH (MM_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.conv),
    .waddr (write_slot),
    .wdata (mm),
    .raddr (slot_dec),
    .rdata (ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count     <= AVG_COUNT_RESET;
      frame_open    <= 1'b0;
      digit_count   <= '0;
      write_slot    <= '0;
      vld           <= '0;
      last_distance <= '0;
      last_average  <= '0;
      pend          <= 1'b0;
      remain        <= '0;
      dcnt          <= '0;
    end else begin
      if (cfg_we) begin
        avg_count <= cfg_data;
      end
      if (cmd.parse) begin
        if (byte_q == BYTE_START) begin
          frame_open  <= 1'b1;
          digit_count <= '0;
        end else if (frame_open && digit_count == 2'd3) begin
          frame_open  <= 1'b0;
          digit_count <= '0;
        end else if (frame_open && is_digit) begin
          digit_count <= digit_count + 2'd1;
        end
      end
      if (cmd.conv) begin
        vld[write_slot] <= 1'b1;
        write_slot      <= (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 :
                           write_slot + SLOT_W'(1);
        last_distance   <= mm;
      end
      if (cmd.setup) begin
        remain <= n_sat;
        pend   <= 1'b0;
      end else if (cmd.walk) begin
        pend <= (remain != '0);
        if (remain != '0) begin
          remain <= remain - CNT_W'(1);
        end
      end
      if (cmd.div_load) begin
        dcnt <= DCNT_W'(SUM_W);
      end else if (cmd.div_step) begin
        dcnt <= dcnt - DCNT_W'(1);
        if (stat.div_last) begin
          last_average <= (good == '0) ? '0 : quo_next[MM_W-1:0];
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= rx_byte;
    end
    if (cmd.load) begin
      done_flag <= 1'b0;
    end else if (cmd.conv) begin
      done_flag <= 1'b1;
    end
    if (cmd.parse) begin
      x_reg <= x_next;
      if (byte_q == BYTE_START || (frame_open && digit_count == 2'd3)) begin
        digit_store[0] <= '0;
        digit_store[1] <= '0;
        digit_store[2] <= '0;
      end else if (frame_open && is_digit) begin
        digit_store[digit_count] <= 4'(byte_q - BYTE_ZERO);
      end
    end
    if (cmd.setup) begin
      slot <= write_slot;
      sum  <= '0;
      good <= '0;
    end else if (cmd.walk) begin
      if (remain != '0) begin
        slot    <= slot_dec;
        pend_ok <= vld[slot_dec];
      end
      if (pend) begin
        sum  <= sum + SUM_W'(entry);
        good <= good + CNT_W'(entry != '0);
      end
    end
    if (cmd.div_load) begin
      quo <= sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= quo_next;
      rem <= ge ? CNT_W'(shifted - {1'b0, good}) : shifted[CNT_W-1:0];
    end
    if (cmd.publish) begin
      frame_done  <= done_flag;
      distance_mm <= last_distance;
      average_mm  <= last_average;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ultrasonic_range_frame_parser.sv =====
// channel   signals                                   direction
// -------   ---------------------------------------   ---------
// in        in_valid, in_stall, rx_byte               sink
// out       out_valid, out_stall, frame_done,         source
//           distance_mm, average_mm
// cfg       cfg_we, cfg_data (avg_count)              sink
//
// One item at a time: no new input is taken until the result of the last
// one is in the output register. Each item passes parse, setup, the ring
// walk over n entries (n = avg_count capped at the ring depth), the divider
// and publish; a byte that completes a frame also passes the convert step.
// The work is set by the ring walk (one read per cycle through the
// registered RAM port) and the one-bit-per-cycle restoring divider.
// Reset clears frame state, the write slot and all ring valid bits at once.
// A stalled result stays on the output register; the block takes the next
// item meanwhile and waits only when the following result is ready.
`default_nettype none
module ultrasonic_range_frame_parser (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [urfp_pkg::AVG_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [7:0]                 rx_byte,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic                       frame_done,
  output      logic [urfp_pkg::MM_W-1:0]  distance_mm,
  output      logic [urfp_pkg::MM_W-1:0]  average_mm
);
  import urfp_pkg::*;

  // command/status between sequencer and datapath
  urfp_cmd_t  cmd;
  urfp_stat_t stat;

  // sequencer: accept, parse, convert, walk the ring, divide, publish
  urfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: frame parser, inch-to-mm via reciprocal multiply,
  // ring RAM with valid bits, sum/count walk and divider
  urfp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .rx_byte     (rx_byte),
    .frame_done  (frame_done),
    .distance_mm (distance_mm),
    .average_mm  (average_mm)
  );

endmodule
`default_nettype wire

// ===== hdl/urfp_chk.sv =====
`default_nettype none
module urfp_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       cfg_we,
  input wire logic [urfp_pkg::AVG_W-1:0] cfg_data,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [7:0]                 rx_byte,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic                       frame_done,
  input wire logic [urfp_pkg::MM_W-1:0]  distance_mm,
  input wire logic [urfp_pkg::MM_W-1:0]  average_mm
);
  import urfp_pkg::*;

  // block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous still in work");

  // a new result only appears while an item is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in work");

  a_values_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (distance_mm <= MM_MAX) && (average_mm <= MM_MAX))
    else $error("distance or average out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_done) &&
      $stable(distance_mm) && $stable(average_mm))
    else $error("stalled result changed");

endmodule

bind ultrasonic_range_frame_parser urfp_chk u_chk (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import urfp_pkg::*;

  // One result item per received byte.
  typedef struct packed {
    logic            done;
    logic [MM_W-1:0] distance;
    logic [MM_W-1:0] avg;
  } reading_t;

  // Directed row: byte to send and, where given is set, the result typed in.
  typedef struct packed {
    logic [7:0]      rx;
    logic            given;
    logic            done;
    logic [MM_W-1:0] distance;
    logic [MM_W-1:0] avg;
  } row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 160;
  localparam int QUIET_PHASE   = 4;
  localparam logic [7:0] BYTE_A = 8'h41;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [AVG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic frame_done;
  logic [MM_W-1:0] distance_mm;
  logic [MM_W-1:0] average_mm;

  // Random idling on both channels; cleared for one whole phase.
  bit idle_on = 1'b1;
  int fails = 0;

  reading_t pending_readings[$];
  reading_t want;

  // Shadow of the parser and ring state.
  bit              open_frame;
  int              digits_held;
  int              digit_val[3];
  logic [MM_W-1:0] ring[RING_DEPTH];
  int              slot;
  logic [MM_W-1:0] last_dist;
  logic [AVG_W-1:0] avg_setting;

  // Directed part: extremes, ignored bytes, restart and drop cases.
  row_t plan[DIRECTED_ROWS] = '{
    '{8'h00,      1'b1, 1'b0, 15'd0,     15'd0},      // reset state, outside frame
    '{8'hFF,      1'b1, 1'b0, 15'd0,     15'd0},
    '{BYTE_START, 1'b1, 1'b0, 15'd0,     15'd0},
    '{BYTE_CR,    1'b1, 1'b0, 15'd0,     15'd0},      // CR before three digits
    '{8'h39,      1'b1, 1'b0, 15'd0,     15'd0},
    '{8'h2F,      1'b1, 1'b0, 15'd0,     15'd0},      // just below '0'
    '{8'h39,      1'b1, 1'b0, 15'd0,     15'd0},
    '{8'h3A,      1'b1, 1'b0, 15'd0,     15'd0},      // just above '9'
    '{8'h39,      1'b1, 1'b0, 15'd0,     15'd0},
    '{BYTE_CR,    1'b1, 1'b1, MM_MAX,    MM_MAX},     // 999 in
    '{BYTE_START, 1'b1, 1'b0, MM_MAX,    MM_MAX},
    '{8'h30,      1'b0, 1'b0, 15'd0,     15'd0},
    '{8'h30,      1'b0, 1'b0, 15'd0,     15'd0},
    '{8'h30,      1'b0, 1'b0, 15'd0,     15'd0},
    '{BYTE_CR,    1'b1, 1'b1, 15'd0,     MM_MAX},     // 0 in, zero entry not counted
    '{BYTE_START, 1'b0, 1'b0, 15'd0,     15'd0},
    '{8'h31,      1'b0, 1'b0, 15'd0,     15'd0},
    '{8'h32,      1'b0, 1'b0, 15'd0,     15'd0},
    '{8'h33,      1'b0, 1'b0, 15'd0,     15'd0},
    '{BYTE_START, 1'b0, 1'b0, 15'd0,     15'd0},      // restart after three digits
    '{8'h30,      1'b0, 1'b0, 15'd0,     15'd0},
    '{8'h30,      1'b0, 1'b0, 15'd0,     15'd0},
    '{8'h31,      1'b0, 1'b0, 15'd0,     15'd0},
    '{BYTE_A,     1'b0, 1'b0, 15'd0,     15'd0},      // wrong byte drops the frame
    '{BYTE_CR,    1'b0, 1'b0, 15'd0,     15'd0}       // ignored, frame is gone
  };

  ultrasonic_range_frame_parser i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_done  (frame_done),
    .distance_mm (distance_mm),
    .average_mm  (average_mm)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parse one byte, update the ring, and work out the average of the newest
  // entries over their nonzero count.
  task automatic next_reading(input logic [7:0] b, output reading_t r);
    int inches;
    int n;
    int good;
    int s;
    int i;
    logic [31:0] sum;
    logic [MM_W-1:0] mm;
    r.done = 1'b0;
    if (b == BYTE_START) begin
      open_frame = 1'b1;
      digits_held = 0;
    end else if (open_frame && digits_held >= 3) begin
      // third digit held: only CR completes, anything else drops
      if (b == BYTE_CR) begin
        inches = 100 * digit_val[0] + 10 * digit_val[1] + digit_val[2];
        mm = MM_W'((254 * inches + 5) / 10);
        ring[slot] = mm;
        slot = (slot + 1) % RING_DEPTH;
        last_dist = mm;
        r.done = 1'b1;
      end
      open_frame = 1'b0;
      digits_held = 0;
    end else if (open_frame && b >= BYTE_ZERO && b <= BYTE_NINE) begin
      digit_val[digits_held] = int'(b - BYTE_ZERO);
      digits_held++;
    end
    // window saturates at the ring depth; zero setting averages nothing
    n = (int'(avg_setting) > RING_DEPTH) ? RING_DEPTH : int'(avg_setting);
    sum = '0;
    good = 0;
    s = slot;
    for (i = 0; i < n; i++) begin
      s = (s == 0) ? RING_DEPTH - 1 : s - 1;
      sum += ring[s];
      if (ring[s] != '0) good++;
    end
    r.avg = (good == 0) ? '0 : MM_W'(sum / good);
    r.distance = last_dist;
  endtask

  // Offer one item and hold it until accepted; then log what it must give.
  // Called right after a rising edge, so the single NBA per step holds.
  task automatic send_byte(input logic [7:0] b, input bit given, input reading_t typed_r);
    reading_t r;
    if (idle_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    next_reading(b, r);
    pending_readings.push_back(given ? typed_r : r);
  endtask

  // Receiver: random stall at a chance of 13 in a hundred while idling is on.
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 13);
  end

  // Result checker: each accepted result item against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $error("result item with no reading pending");
        fails++;
      end else begin
        want = pending_readings.pop_front();
        if (frame_done !== want.done) begin
          $error("frame_done: expected %0d, got %0d", want.done, frame_done);
          fails++;
        end
        if (distance_mm !== want.distance) begin
          $error("distance_mm: expected %0d, got %0d", want.distance, distance_mm);
          fails++;
        end
        if (average_mm !== want.avg) begin
          $error("average_mm: expected %0d, got %0d", want.avg, average_mm);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [AVG_W-1:0] settings[PHASES];
    logic [7:0] frame_bytes[$];
    reading_t none;
    logic [7:0] b;
    int inches;
    int kind;
    int k;
    int sent;
    int p;
    int i;

    none = '0;
    // shadow state after reset
    open_frame = 1'b0;
    digits_held = 0;
    foreach (digit_val[i]) digit_val[i] = 0;
    foreach (ring[i]) ring[i] = '0;
    slot = 0;
    last_dist = '0;
    avg_setting = AVG_COUNT_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs with the reset window of 16
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_byte(plan[i].rx, plan[i].given,
                '{plan[i].done, plan[i].distance, plan[i].avg});
    end
    in_valid <= 1'b0;

    // window settings: smallest, zero, top of the field, just past depth,
    // exactly depth (quiet phase), then small and random ones
    settings[0] = 5'd1;
    settings[1] = 5'd0;
    settings[2] = 5'd31;
    settings[3] = 5'd17;
    settings[4] = 5'd16;
    settings[5] = 5'd2;
    settings[6] = AVG_W'($urandom_range(0, 31));
    settings[7] = AVG_W'($urandom_range(1, 16));

    for (p = 0; p < PHASES; p++) begin
      // register writes only with nothing in flight
      while (pending_readings.size() != 0) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_data <= settings[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      avg_setting = settings[p];
      idle_on = (p != QUIET_PHASE);

      sent = 0;
      while (sent < PHASE_BYTES) begin
        frame_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 70) begin
          // well-formed frame, sometimes with ignored bytes before the third digit
          k = $urandom_range(9);
          inches = (k == 0) ? 999 : (k == 1) ? 0 : $urandom_range(0, 999);
          frame_bytes.push_back(BYTE_START);
          for (i = 0; i < 3; i++) begin
            if ($urandom_range(99) < 15) begin
              b = 8'($urandom_range(0, 255));
              if (b == BYTE_START || (b >= BYTE_ZERO && b <= BYTE_NINE)) b = BYTE_CR;
              frame_bytes.push_back(b);
            end
            k = (i == 0) ? inches / 100 : (i == 1) ? (inches / 10) % 10 : inches % 10;
            frame_bytes.push_back(BYTE_ZERO + 8'(k));
          end
          frame_bytes.push_back(BYTE_CR);
        end else if (kind < 85) begin
          // broken frame: up to three digits, then any byte
          frame_bytes.push_back(BYTE_START);
          k = $urandom_range(0, 3);
          for (i = 0; i < k; i++) frame_bytes.push_back(BYTE_ZERO + 8'($urandom_range(0, 9)));
          frame_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          // line noise
          k = $urandom_range(1, 3);
          for (i = 0; i < k; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, none);
        sent += frame_bytes.size();
      end
      in_valid <= 1'b0;
    end

    // drain, then give the block time to show any stray result
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run.
  initial begin : watchdog
    #15_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
